// ===== rtl/core/radix_string_to_integer_macros.svh =====
// Assertion macros used by the radix string parser checker.
`ifndef RADIX_STRING_TO_INTEGER_MACROS_SVH
`define RADIX_STRING_TO_INTEGER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rsi_pkg.sv =====
// Types, constants and the digit decoder of the radix string parser.
`default_nettype none

package rsi_pkg;

    localparam int unsigned VALUE_BITS = 64;
    localparam int unsigned COUNT_BITS = 16;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [6:0]            digit_t;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SIGN,
        PH_MID,
        PH_DIGITS
    } phase_t;

    localparam logic [2:0] REG_RADIX      = 3'd0;
    localparam logic [2:0] REG_FILL_CHAR  = 3'd1;
    localparam logic [2:0] REG_MINUS_CHAR = 3'd2;
    localparam logic [2:0] REG_PLUS_CHAR  = 3'd3;
    localparam logic [2:0] REG_FILL_MODE  = 3'd4;
    localparam logic [2:0] REG_CASE_MODE  = 3'd5;

    localparam logic [1:0] FILL_BEFORE = 2'd0;
    localparam logic [1:0] CASE_EITHER = 2'd0;
    localparam logic [1:0] CASE_UPPER  = 2'd1;
    localparam logic [1:0] CASE_LOWER  = 2'd2;

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;

    localparam logic [5:0] RESET_RADIX      = 6'd10;
    localparam logic [7:0] RESET_MINUS_CHAR = 8'd45;
    localparam logic [7:0] RESET_PLUS_CHAR  = 8'd43;

    localparam logic [7:0] CHR_NUL     = 8'h00;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] UPPER_BIAS  = 8'd55;
    localparam logic [7:0] LOWER_BIAS  = 8'd87;

    localparam digit_t DIGIT_NONE = 7'd99;

    function automatic digit_t digit_of(input logic [7:0] c, input logic [1:0] case_mode);
        logic   up_ok;
        logic   lo_ok;
        logic [7:0] diff;
        digit_t d;
        up_ok = (case_mode != CASE_LOWER);
        lo_ok = (case_mode != CASE_UPPER);
        d     = DIGIT_NONE;
        diff  = '0;
        if (c >= CHR_ZERO && c <= CHR_NINE) begin
            diff = c - CHR_ZERO;
            d    = diff[6:0];
        end else if (up_ok && c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
            diff = c - UPPER_BIAS;
            d    = diff[6:0];
        end else if (lo_ok && c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
            diff = c - LOWER_BIAS;
            d    = diff[6:0];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/radix_string_to_integer.sv =====
// Top level of the radix string parser: one character per item, one number per string.
//
// Input channel (s_): one character per item in s_tdata, s_tuser set on the first
// character of a string. Leading fill, an optional sign and digits of the configured
// radix are taken until the first character that does not fit; that character ends
// the string and one result item leaves on the output channel (m_): the signed value
// wrapped to 64 bits and the saturating count of consumed characters in m_tdata, and
// the bad radix flag in m_tuser. Items arriving after the end are dropped until the
// next start. Configuration is written through cfg_wr_en, cfg_addr and cfg_wdata.
// An item waits in the input register; a result that it ends goes to the output register
// behind m_tvalid. Throughput is one item per cycle unless a held result stalls it, set by the
// single multiply-accumulate of a 64-bit value by a 6-bit radix.
// A result waiting on a stalled receiver holds the output register; the block keeps
// taking items that end no string, and stops at the first one that would.
// Reset clears the channels, sets the configuration registers to their defaults
// and leaves the parser waiting for a start.
`default_nettype none

module radix_string_to_integer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // chr[7:0]
    input  wire logic        s_tuser,   // start_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // value[63:0], consumed[79:64]
    output logic             m_tuser    // bad_radix
);
    import rsi_pkg::*;

    logic       radix_reg;
    logic [5:0] radix_val_reg;
    logic [7:0] fill_char_reg;
    logic [7:0] minus_char_reg;
    logic [7:0] plus_char_reg;
    logic [1:0] fill_mode_reg;
    logic [1:0] case_mode_reg;

    logic       in_valid_reg;
    logic [7:0] chr_reg;
    logic       start_reg;

    phase_t phase_reg, phase_next;
    logic   neg_reg, neg_next;
    value_t acc_reg, acc_next;
    count_t cnt_reg, cnt_next;
    logic   stopped_reg, stopped_next;

    logic   out_valid_reg;
    value_t out_value_reg;
    count_t out_count_reg;
    logic   out_bad_reg;

    phase_t cur_phase;
    logic   cur_neg;
    value_t cur_acc;
    count_t cur_cnt;
    logic   cur_stop;

    logic   fill_on;
    logic   is_fill;
    logic   is_minus;
    logic   is_plus;
    logic   at_sign;
    logic   at_mid;
    logic   lead_skip;
    logic   sign_take;
    logic   mid_skip;
    logic   bad_radix;
    digit_t digit;
    logic   digit_ok;
    value_t acc_mac;
    count_t cnt_inc;

    logic   res_valid;
    value_t res_value;
    count_t res_count;
    logic   res_bad;
    logic   adv;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= 1'b1;
            radix_val_reg  <= RESET_RADIX;
            fill_char_reg  <= CHR_NUL;
            minus_char_reg <= RESET_MINUS_CHAR;
            plus_char_reg  <= RESET_PLUS_CHAR;
            fill_mode_reg  <= FILL_BEFORE;
            case_mode_reg  <= CASE_EITHER;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RADIX: begin
                    radix_val_reg <= cfg_wdata[5:0];
                    radix_reg     <= (cfg_wdata[5:0] >= RADIX_MIN)
                                     && (cfg_wdata[5:0] <= RADIX_MAX);
                end
                REG_FILL_CHAR:  fill_char_reg  <= cfg_wdata;
                REG_MINUS_CHAR: minus_char_reg <= cfg_wdata;
                REG_PLUS_CHAR:  plus_char_reg  <= cfg_wdata;
                REG_FILL_MODE:  fill_mode_reg  <= cfg_wdata[1:0];
                REG_CASE_MODE:  case_mode_reg  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    assign bad_radix = !radix_reg;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready || !res_valid);
    assign s_tready = !in_valid_reg || adv;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            chr_reg   <= s_tdata;
            start_reg <= s_tuser;
        end
    end

    // A start character restarts the string before it is looked at.
    assign cur_phase = start_reg ? PH_LEAD : phase_reg;
    assign cur_neg   = start_reg ? 1'b0 : neg_reg;
    assign cur_acc   = start_reg ? '0 : acc_reg;
    assign cur_cnt   = start_reg ? '0 : cnt_reg;
    assign cur_stop  = start_reg ? 1'b0 : stopped_reg;

    assign fill_on  = (fill_char_reg != CHR_NUL);
    assign is_fill  = fill_on && (chr_reg == fill_char_reg);
    assign is_minus = (minus_char_reg != CHR_NUL) && (chr_reg == minus_char_reg);
    assign is_plus  = (plus_char_reg != CHR_NUL) && (chr_reg == plus_char_reg);

    assign at_sign   = (cur_phase == PH_LEAD) || (cur_phase == PH_SIGN);
    assign at_mid    = at_sign || (cur_phase == PH_MID);
    assign lead_skip = (cur_phase == PH_LEAD) && is_fill && (fill_mode_reg == FILL_BEFORE);
    assign sign_take = at_sign && (is_minus || is_plus);
    // Fill after the sign, or in its place, is skipped in modes one and three.
    assign mid_skip  = at_mid && is_fill && fill_mode_reg[0];

    assign digit    = digit_of(chr_reg, case_mode_reg);
    assign digit_ok = digit < {1'b0, radix_val_reg};
    assign acc_mac  = cur_acc * value_t'(radix_val_reg) + value_t'(digit);
    assign cnt_inc  = (cur_cnt == '1) ? cur_cnt : cur_cnt + count_t'(1);

    always_comb begin
        phase_next   = cur_phase;
        neg_next     = cur_neg;
        acc_next     = cur_acc;
        cnt_next     = cur_cnt;
        stopped_next = cur_stop;
        res_valid    = 1'b0;
        res_value    = cur_neg ? value_t'(-cur_acc) : cur_acc;
        res_count    = cur_cnt;
        res_bad      = 1'b0;
        if (!cur_stop) begin
            priority if (bad_radix) begin
                stopped_next = 1'b1;
                res_valid    = 1'b1;
                res_bad      = 1'b1;
                res_value    = '0;
                res_count    = '0;
            end else if (lead_skip) begin
                cnt_next = cnt_inc;
            end else if (sign_take) begin
                phase_next = PH_MID;
                neg_next   = is_minus;
                cnt_next   = cnt_inc;
            end else if (mid_skip) begin
                phase_next = PH_MID;
                cnt_next   = cnt_inc;
            end else if (digit_ok) begin
                phase_next = PH_DIGITS;
                acc_next   = acc_mac;
                cnt_next   = cnt_inc;
            end else begin
                phase_next   = PH_DIGITS;
                stopped_next = 1'b1;
                res_valid    = 1'b1;
            end
        end
    end

    // Parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEAD;
            neg_reg     <= 1'b0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            stopped_reg <= 1'b1;
        end else if (adv) begin
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            stopped_reg <= stopped_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res_valid) begin
            out_value_reg <= res_value;
            out_count_reg <= res_count;
            out_bad_reg   <= res_bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_value_reg};
    assign m_tuser  = out_bad_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rsi_checker.sv =====
// Port-level checks of the radix string parser, bound to its top level.
`default_nettype none

`include "radix_string_to_integer_macros.svh"

module rsi_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic        m_tuser
);

    `RSI_ASSERT_NOW(a_bad_radix_zero, m_tvalid && m_tuser, m_tdata == 80'd0, "bad radix item carries data")

    `RSI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled item changed")

    `RSI_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

    `RSI_ASSERT_NEXT(a_no_item_from_nothing, !m_tvalid && !$past(s_tvalid && s_tready), !m_tvalid, "result without an input item")

endmodule

bind radix_string_to_integer rsi_checker u_rsi_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the radix string parser: directed and random strings checked against an in-bench predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rsi_pkg::*;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam logic [1:0] FILL_AFTER       = 2'd1;
    localparam logic [1:0] FILL_RIGHT       = 2'd2;
    localparam logic [1:0] FILL_AFTER_ALIAS = 2'd3;
    localparam logic [1:0] CASE_EITHER_ALIAS = 2'd3;

    localparam logic [7:0] CHR_SPACE      = 8'h20;
    localparam logic [7:0] CHR_HASH       = 8'h23;
    localparam logic [7:0] CHR_STAR       = 8'h2A;
    localparam logic [7:0] CHR_PLUS       = 8'h2B;
    localparam logic [7:0] CHR_MINUS      = 8'h2D;
    localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHR_X          = 8'h78;
    localparam logic [7:0] CHR_HIGH       = 8'h80;
    localparam logic [7:0] CHR_TOP        = 8'hFF;

    localparam int NOT_DIGIT     = 99;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 22;
    localparam int MAX_PRINTED   = 20;

    typedef struct packed {
        value_t value;
        count_t consumed;
        logic   bad_radix;
    } parse_result_t;

    typedef struct {
        logic [7:0] chr;
        logic       start;
    } char_item_t;

    typedef struct {
        logic [7:0] radix_w;
        logic [7:0] fill;
        logic [7:0] minus;
        logic [7:0] plus;
        logic [7:0] fmode_w;
        logic [7:0] cmode_w;
    } setup_t;

    class number_scoreboard;
        logic [5:0]    radix;
        logic [7:0]    fill_char;
        logic [7:0]    minus_char;
        logic [7:0]    plus_char;
        logic [1:0]    fill_mode;
        logic [1:0]    case_mode;
        phase_t        phase;
        logic          negative;
        value_t        acc;
        count_t        count;
        logic          stopped;
        parse_result_t pending[$];
        int            errors;
        int            checked;
        int            bad_seen;

        function new();
            radix      = RESET_RADIX;
            fill_char  = CHR_NUL;
            minus_char = RESET_MINUS_CHAR;
            plus_char  = RESET_PLUS_CHAR;
            fill_mode  = FILL_BEFORE;
            case_mode  = CASE_EITHER;
            phase      = PH_LEAD;
            negative   = 1'b0;
            acc        = '0;
            count      = '0;
            stopped    = 1'b1;
            errors     = 0;
            checked    = 0;
            bad_seen   = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] d);
            case (idx)
                REG_RADIX:      radix = d[5:0];
                REG_FILL_CHAR:  fill_char = d;
                REG_MINUS_CHAR: minus_char = d;
                REG_PLUS_CHAR:  plus_char = d;
                REG_FILL_MODE:  fill_mode = d[1:0];
                REG_CASE_MODE:  case_mode = d[1:0];
                default: ;
            endcase
        endfunction

        function int digit_value(logic [7:0] c);
            if (c >= CHR_ZERO && c <= CHR_NINE)
                return int'(c) - int'(CHR_ZERO);
            if (case_mode != CASE_LOWER && c >= CHR_UPPER_A && c <= CHR_UPPER_Z)
                return int'(c) - int'(CHR_UPPER_A) + 10;
            if (case_mode != CASE_UPPER && c >= CHR_LOWER_A && c <= CHR_LOWER_Z)
                return int'(c) - int'(CHR_LOWER_A) + 10;
            return NOT_DIGIT;
        endfunction

        function void take_char();
            if (count != '1)
                count++;
        endfunction

        function void note_char(logic [7:0] c, logic st);
            int            d;
            parse_result_t r;
            if (st) begin
                phase    = PH_LEAD;
                negative = 1'b0;
                acc      = '0;
                count    = '0;
                stopped  = 1'b0;
            end
            if (stopped)
                return;
            if (radix < RADIX_MIN || radix > RADIX_MAX) begin
                stopped     = 1'b1;
                r.value     = '0;
                r.consumed  = '0;
                r.bad_radix = 1'b1;
                pending.push_back(r);
                return;
            end
            if (phase == PH_LEAD) begin
                if (fill_char != CHR_NUL && fill_mode == FILL_BEFORE && c == fill_char) begin
                    take_char();
                    return;
                end
                phase = PH_SIGN;
            end
            if (phase == PH_SIGN) begin
                phase = PH_MID;
                if (minus_char != CHR_NUL && c == minus_char) begin
                    negative = 1'b1;
                    take_char();
                    return;
                end
                if (plus_char != CHR_NUL && c == plus_char) begin
                    take_char();
                    return;
                end
            end
            if (phase == PH_MID) begin
                if (fill_char != CHR_NUL && fill_mode[0] && c == fill_char) begin
                    take_char();
                    return;
                end
                phase = PH_DIGITS;
            end
            d = digit_value(c);
            if (d < int'(radix)) begin
                acc = acc * radix + value_t'(d);
                take_char();
                return;
            end
            stopped     = 1'b1;
            r.value     = negative ? value_t'(-acc) : acc;
            r.consumed  = count;
            r.bad_radix = 1'b0;
            pending.push_back(r);
        endfunction

        task report(input string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("ERROR at %0t ns: %s", $time, what);
        endtask

        task check_result(input value_t v, input count_t n, input logic b);
            parse_result_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result: value %0d consumed %0d bad_radix %0b",
                                 $signed(v), n, b));
                return;
            end
            e = pending.pop_front();
            checked++;
            if (v !== e.value)
                report($sformatf("value %0d, expected %0d", $signed(v), $signed(e.value)));
            if (n !== e.consumed)
                report($sformatf("consumed %0d, expected %0d", n, e.consumed));
            if (b !== e.bad_radix)
                report($sformatf("bad_radix %0b, expected %0b", b, e.bad_radix));
            if (e.bad_radix)
                bad_seen++;
        endtask

        task leftover_check();
            if (pending.size() != 0)
                report($sformatf("%0d results never arrived", pending.size()));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;

    number_scoreboard sb = new();
    setup_t           cur;
    char_item_t       text[$];
    int               burst_max = 4;
    int               gap_max = 2;
    int               burst_left = 1;
    bit               hold_req = 1'b0;
    int               strings_sent = 0;
    int               holdoffs = 0;
    int               setups_run = 0;

    radix_string_to_integer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[63:0], m_tdata[79:64], m_tuser);
            if (s_tvalid && s_tready)
                sb.note_char(s_tdata, s_tuser);
        end
    end

    // Receiver: the stall pattern is redrawn at random; a hold-off request
    // keeps it stalled long enough for the parser to back up its input.
    initial begin
        int mode;
        int left;
        int cycle;
        mode  = 0;
        left  = 0;
        cycle = 0;
        forever begin
            @(posedge aclk);
            cycle++;
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                holdoffs++;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 120);
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (cycle % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_char(input logic [7:0] c, input logic st);
        int gap;
        s_tdata  <= c;
        s_tuser  <= st;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_text();
        foreach (text[i])
            send_char(text[i].chr, text[i].start);
        strings_sent++;
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] d);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        sb.write_reg(idx, d);
    endtask

    task automatic load_setup(input setup_t s);
        if ($urandom_range(0, 2) == 0)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 8'($urandom));
        cfg_write(REG_RADIX, s.radix_w);
        cfg_write(REG_FILL_CHAR, s.fill);
        cfg_write(REG_MINUS_CHAR, s.minus);
        cfg_write(REG_PLUS_CHAR, s.plus);
        cfg_write(REG_FILL_MODE, s.fmode_w);
        cfg_write(REG_CASE_MODE, s.cmode_w);
        cfg_wr_en <= 1'b0;
        cur = s;
        setups_run++;
    endtask

    task automatic pick_pace();
        case ($urandom_range(0, 3))
            0: begin burst_max = 1000; gap_max = 0; end
            1: begin burst_max = 8;    gap_max = 3; end
            2: begin burst_max = 3;    gap_max = 8; end
            default: begin burst_max = 1; gap_max = 1; end
        endcase
        burst_left = $urandom_range(1, burst_max);
    endtask

    function automatic setup_t reset_setup();
        setup_t s;
        s.radix_w = {2'b00, RESET_RADIX};
        s.fill    = CHR_NUL;
        s.minus   = RESET_MINUS_CHAR;
        s.plus    = RESET_PLUS_CHAR;
        s.fmode_w = {6'd0, FILL_BEFORE};
        s.cmode_w = {6'd0, CASE_EITHER};
        return s;
    endfunction

    function automatic setup_t random_setup();
        setup_t s;
        s.radix_w = {2'($urandom), 6'($urandom_range(2, 36))};
        if ($urandom_range(0, 9) == 0)
            s.radix_w = 8'($urandom);
        case ($urandom_range(0, 4))
            0: s.fill = CHR_NUL;
            1: s.fill = CHR_SPACE;
            2: s.fill = CHR_ZERO;
            3: s.fill = CHR_STAR;
            default: s.fill = 8'($urandom);
        endcase
        case ($urandom_range(0, 3))
            1: s.minus = CHR_NUL;
            2: s.minus = 8'($urandom);
            default: s.minus = CHR_MINUS;
        endcase
        case ($urandom_range(0, 3))
            0: s.plus = CHR_PLUS;
            1: s.plus = CHR_NUL;
            2: s.plus = s.minus;
            default: s.plus = 8'($urandom);
        endcase
        s.fmode_w = 8'($urandom);
        s.cmode_w = 8'($urandom);
        return s;
    endfunction

    // The first setups force the register extremes and the odd cases, the rest are random.
    function automatic setup_t phase_setup(int p);
        setup_t s;
        s = random_setup();
        case (p)
            0: begin s.radix_w = 8'd2; s.fill = CHR_NUL; s.cmode_w = {6'd0, CASE_EITHER}; end
            1: begin s.radix_w = 8'd36; s.cmode_w = {6'h3F, CASE_UPPER}; end
            2: begin
                s.radix_w = 8'd36;
                s.cmode_w = {6'd0, CASE_LOWER};
                s.fill    = CHR_ZERO;
                s.fmode_w = {6'd0, FILL_BEFORE};
            end
            3: begin s.radix_w = 8'd16; s.fill = CHR_SPACE; s.fmode_w = {6'd0, FILL_AFTER}; end
            4: begin s.radix_w = 8'd10; s.fill = CHR_UNDERSCORE; s.fmode_w = {6'd0, FILL_RIGHT}; end
            5: begin
                s.radix_w = 8'd35;
                s.fill    = CHR_STAR;
                s.fmode_w = {6'h2A, FILL_AFTER_ALIAS};
                s.cmode_w = {6'd0, CASE_EITHER_ALIAS};
            end
            6: s.radix_w = 8'd0;
            7: s.radix_w = 8'hFF;
            8: s.radix_w = 8'd37;
            9: s.radix_w = 8'd1;
            10: begin
                s.radix_w = 8'h4A;
                s.minus   = CHR_HASH;
                s.plus    = CHR_HASH;
                s.fill    = CHR_TOP;
                s.fmode_w = {6'd0, FILL_BEFORE};
            end
            11: begin s.minus = CHR_NUL; s.plus = CHR_NUL; end
            12: begin s.minus = CHR_TOP; s.plus = CHR_MINUS; end
            default: ;
        endcase
        return s;
    endfunction

    function automatic void add_char(logic [7:0] c, logic st);
        char_item_t it;
        it.chr   = c;
        it.start = st;
        text.push_back(it);
    endfunction

    function automatic logic [7:0] digit_char(int v);
        if (v < 10)
            return CHR_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CHR_UPPER_A : CHR_LOWER_A) + 8'(v - 10);
    endfunction

    // Most strings are well formed for the current setup; the rest are random noise.
    function automatic void build_text();
        int         r;
        int         n;
        logic [7:0] fill;
        logic [1:0] fm;
        text.delete();
        r = cur.radix_w[5:0];
        if (r < RADIX_MIN || r > RADIX_MAX)
            r = 10;
        fill = cur.fill;
        fm   = cur.fmode_w[1:0];
        if ($urandom_range(0, 9) < 8) begin
            if (fill != CHR_NUL && fm == FILL_BEFORE)
                repeat ($urandom_range(0, 3)) add_char(fill, 1'b0);
            case ($urandom_range(0, 2))
                0: if (cur.minus != CHR_NUL) add_char(cur.minus, 1'b0);
                1: if (cur.plus != CHR_NUL) add_char(cur.plus, 1'b0);
                default: ;
            endcase
            if (fill != CHR_NUL && fm[0])
                repeat ($urandom_range(0, 3)) add_char(fill, 1'b0);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 30) : $urandom_range(0, 8);
            repeat (n) add_char(digit_char($urandom_range(0, r - 1)), 1'b0);
            if (fill != CHR_NUL && fm == FILL_RIGHT)
                repeat ($urandom_range(0, 3)) add_char(fill, 1'b0);
            add_char($urandom_range(0, 1) ? CHR_NUL : 8'($urandom), 1'b0);
            text[0].start = 1'b1;
        end else begin
            repeat ($urandom_range(1, 6)) add_char(8'($urandom), $urandom_range(0, 2) == 0);
        end
    endfunction

    task automatic run_directed();
        setup_t s;
        text.delete();
        add_char(CHR_ZERO, 1'b1);
        add_char(CHR_NUL, 1'b0);
        send_text();
        text.delete();
        add_char(CHR_MINUS, 1'b1);
        add_char(CHR_ZERO + 8'd1, 1'b0);
        add_char(CHR_ZERO + 8'd2, 1'b0);
        add_char(CHR_ZERO + 8'd3, 1'b0);
        add_char(CHR_NUL, 1'b0);
        send_text();
        text.delete();
        add_char(CHR_PLUS, 1'b1);
        add_char(CHR_NINE, 1'b0);
        add_char(CHR_X, 1'b0);
        send_text();
        text.delete();
        add_char(CHR_NUL, 1'b1);
        // Nothing running: a character without a start is dropped.
        add_char(CHR_UPPER_A, 1'b0);
        send_text();
        text.delete();
        // A start in the middle of a string abandons it.
        add_char(CHR_ZERO + 8'd1, 1'b1);
        add_char(CHR_ZERO + 8'd2, 1'b0);
        add_char(CHR_ZERO + 8'd7, 1'b1);
        add_char(CHR_TOP, 1'b0);
        add_char(CHR_HIGH, 1'b1);
        send_text();
        wait_results();
        s = reset_setup();
        s.radix_w = 8'd37;
        load_setup(s);
        text.delete();
        add_char(CHR_ZERO + 8'd5, 1'b1);
        add_char(CHR_ZERO + 8'd6, 1'b0);
        send_text();
        wait_results();
        s = reset_setup();
        s.radix_w = 8'd36;
        s.minus   = CHR_HASH;
        s.plus    = CHR_HASH;
        load_setup(s);
        text.delete();
        add_char(CHR_HASH, 1'b1);
        add_char(CHR_LOWER_Z, 1'b0);
        add_char(CHR_UPPER_Z, 1'b0);
        add_char(CHR_NUL, 1'b0);
        send_text();
    endtask

    initial begin
        int     p;
        int     target;
        int     sent;
        bit     mid_done;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();

        for (p = 0; p < PHASES; p++) begin
            wait_results();
            load_setup(phase_setup(p));
            pick_pace();
            target   = (cur.radix_w[5:0] < RADIX_MIN || cur.radix_w[5:0] > RADIX_MAX) ? 15 : 50;
            sent     = 0;
            mid_done = 1'b0;
            while (sent < target) begin
                if (!mid_done && sent >= target / 2) begin
                    mid_done = 1'b1;
                    if (p % 5 == 2)
                        hold_req = 1'b1;
                    else if (p % 5 == 4)
                        wait_results();
                end
                build_text();
                send_text();
                sent += text.size();
            end
        end

        wait_results();
        repeat (20) @(posedge aclk);
        sb.leftover_check();
        $display("Run covered %0d strings under %0d register setups; %0d results checked,",
                 strings_sent, setups_run, sb.checked);
        $display("%0d of them bad radix; receiver held off %0d times for %0d cycles; %0d errors.",
                 sb.bad_seen, holdoffs, HOLD_CYCLES, sb.errors);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rsi_pkg.sv
rtl/core/radix_string_to_integer.sv
rtl/core/rsi_checker.sv
tb/sv/tb_top.sv
